### hdl/jtss_pkg.sv
// ----------------------------------------------------------------------------
// JTAG TAP shift sequencer package
// Shared command codes, sequencer phases and item layouts.
// ----------------------------------------------------------------------------
package jtss_pkg;

	// command codes carried in the input kind field
	typedef enum logic [2:0] {
		FUNC_TICK  = 3'd0,
		FUNC_RESET = 3'd1,
		FUNC_IR    = 3'd2,
		FUNC_DR    = 3'd3,
		FUNC_WAIT  = 3'd4
	} func_t;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_RESET      = 4'd1,
		PH_SEL_DR     = 4'd2,
		PH_SEL_IR     = 4'd3,
		PH_TO_CAPTURE = 4'd4,
		PH_TO_SHIFT   = 4'd5,
		PH_SHIFT      = 4'd6,
		PH_UPDATE     = 4'd7,
		PH_RTI        = 4'd8,
		PH_WAIT       = 4'd9
	} phase_t;

	localparam int FUNC_W  = 3;
	localparam int COUNT_W = 6;
	localparam int VALUE_W = 32;
	localparam int WAIT_W  = 24;
	localparam int CAP_W   = 32;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	// one input item
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [COUNT_W-1:0] bit_count;
		logic [VALUE_W-1:0] shift_value;
		logic [WAIT_W-1:0]  wait_ticks;
		logic               tdo_level;
	} item_t;

	// one result item
	typedef struct packed {
		logic             tms_level;
		logic             tdi_level;
		logic             tck_pulse;
		logic             busy_res;
		logic             done_res;
		logic [CAP_W-1:0] captured;
		logic             rejected;
	} result_t;

endpackage

### hdl/jtss_step.sv
// ----------------------------------------------------------------------------
// JTAG TAP shift sequencer step
// Next-state and result logic for one item against the current sequencer state.
// ----------------------------------------------------------------------------
module jtss_step #(
	parameter int MAX_SHIFT_BITS   = 32,
	parameter int RESET_TMS_CLOCKS = 8,
	parameter int CNT_W            = 6,
	parameter int TICK_W           = 24,
	parameter int WAIT_USED_W      = 24
) (
	input  jtss_pkg::item_t               item,
	input  jtss_pkg::phase_t              phase,
	input  jtss_pkg::func_t               cmd,
	input  logic [CNT_W-1:0]              bits_left,
	input  logic [CNT_W-1:0]              shift_total,
	input  logic [MAX_SHIFT_BITS-1:0]     shift_reg,
	input  logic [TICK_W-1:0]             ticks_left,
	input  logic                          tdi_hold,
	output jtss_pkg::phase_t              phase_nx,
	output jtss_pkg::func_t               cmd_nx,
	output logic [CNT_W-1:0]              bits_left_nx,
	output logic [CNT_W-1:0]              shift_total_nx,
	output logic [MAX_SHIFT_BITS-1:0]     shift_reg_nx,
	output logic [TICK_W-1:0]             ticks_left_nx,
	output logic                          tdi_hold_nx,
	output jtss_pkg::result_t             res
);

	localparam int SW = MAX_SHIFT_BITS;

	logic              is_cmd;
	logic [CNT_W-1:0]  cnt_eff;
	logic [SW-1:0]     load_mask;
	logic [SW-1:0]     total_mask;
	logic [TICK_W-1:0] wait_eff;
	logic [TICK_W-1:0] ticks_dec;
	logic [CNT_W-1:0]  bits_dec;

	// clamp the shift length to one .. MAX_SHIFT_BITS
	always_comb begin
		if (item.bit_count == '0) begin
			cnt_eff = CNT_W'(1);
		end else if ({1'b0, item.bit_count} > (jtss_pkg::COUNT_W + 1)'(SW)) begin
			cnt_eff = CNT_W'(SW);
		end else begin
			cnt_eff = CNT_W'(item.bit_count);
		end
	end

	assign load_mask  = ~({SW{1'b1}} << cnt_eff);
	assign total_mask = ~({SW{1'b1}} << shift_total);
	assign ticks_dec  = ticks_left - TICK_W'(1);
	assign bits_dec   = (bits_left != '0) ? bits_left - CNT_W'(1) : bits_left;

	// wait length: keep the counted bits, zero stands for one tick
	always_comb begin
		wait_eff = TICK_W'(item.wait_ticks[WAIT_USED_W-1:0]);
		if (wait_eff == '0) begin
			wait_eff = TICK_W'(1);
		end
	end

	assign is_cmd = (item.func == jtss_pkg::FUNC_RESET) || (item.func == jtss_pkg::FUNC_IR)
		|| (item.func == jtss_pkg::FUNC_DR) || (item.func == jtss_pkg::FUNC_WAIT);

	// advance the sequencer by one item
	always_comb begin
		phase_nx       = phase;
		cmd_nx         = cmd;
		bits_left_nx   = bits_left;
		shift_total_nx = shift_total;
		shift_reg_nx   = shift_reg;
		ticks_left_nx  = ticks_left;
		tdi_hold_nx    = tdi_hold;
		res            = '0;
		res.tdi_level  = tdi_hold;
		if (is_cmd) begin
			res.busy_res = 1'b1;
			if (phase != jtss_pkg::PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				cmd_nx = jtss_pkg::func_t'(item.func);
				case (jtss_pkg::func_t'(item.func))
					jtss_pkg::FUNC_RESET: begin
						ticks_left_nx = TICK_W'(RESET_TMS_CLOCKS);
						phase_nx      = jtss_pkg::PH_RESET;
					end
					jtss_pkg::FUNC_WAIT: begin
						ticks_left_nx = wait_eff;
						phase_nx      = jtss_pkg::PH_WAIT;
					end
					default: begin
						shift_total_nx = cnt_eff;
						bits_left_nx   = cnt_eff;
						shift_reg_nx   = SW'(item.shift_value) & load_mask;
						phase_nx       = jtss_pkg::PH_SEL_DR;
					end
				endcase
			end
		end else if (phase != jtss_pkg::PH_IDLE) begin
			res.tck_pulse = 1'b1;
			case (phase)
				jtss_pkg::PH_RESET: begin
					res.tms_level = 1'b1;
					ticks_left_nx = ticks_dec;
					if (ticks_dec == '0) begin
						phase_nx     = jtss_pkg::PH_IDLE;
						res.done_res = 1'b1;
					end
				end
				jtss_pkg::PH_WAIT: begin
					ticks_left_nx = ticks_dec;
					if (ticks_dec == '0) begin
						phase_nx     = jtss_pkg::PH_IDLE;
						res.done_res = 1'b1;
					end
				end
				jtss_pkg::PH_SEL_DR: begin
					res.tms_level = 1'b1;
					phase_nx = (cmd == jtss_pkg::FUNC_IR) ? jtss_pkg::PH_SEL_IR
						: jtss_pkg::PH_TO_CAPTURE;
				end
				jtss_pkg::PH_SEL_IR: begin
					res.tms_level = 1'b1;
					phase_nx      = jtss_pkg::PH_TO_CAPTURE;
				end
				jtss_pkg::PH_TO_CAPTURE: begin
					phase_nx = jtss_pkg::PH_TO_SHIFT;
				end
				jtss_pkg::PH_TO_SHIFT: begin
					phase_nx = jtss_pkg::PH_SHIFT;
				end
				jtss_pkg::PH_SHIFT: begin
					res.tdi_level = shift_reg[0];
					tdi_hold_nx   = shift_reg[0];
					res.tms_level = (bits_left <= CNT_W'(1));
					// drop the sent bit, insert TDO at the top of the run
					shift_reg_nx  = (shift_reg >> 1)
						| (SW'(item.tdo_level) << (shift_total - CNT_W'(1)));
					bits_left_nx  = bits_dec;
					if (bits_dec == '0) begin
						phase_nx = jtss_pkg::PH_UPDATE;
					end
				end
				jtss_pkg::PH_UPDATE: begin
					res.tms_level = 1'b1;
					phase_nx      = jtss_pkg::PH_RTI;
				end
				default: begin
					phase_nx     = jtss_pkg::PH_IDLE;
					res.done_res = 1'b1;
					res.captured = jtss_pkg::CAP_W'(shift_reg & total_mask);
				end
			endcase
			res.busy_res = (phase_nx != jtss_pkg::PH_IDLE);
		end
	end

endmodule

### hdl/jtag_tap_shift_sequencer_core.sv
// ----------------------------------------------------------------------------
// JTAG TAP shift sequencer core
// Master-side JTAG sequencer driven by command and tick items.
// ----------------------------------------------------------------------------
// One item is taken per clock and each item gives exactly one result. An item
// is held in the input register, the whole sequencer step (phase walk, shift,
// counters) is combinational between that register and the result register,
// so a result is offered on m_tvalid from the result register once the held
// item is stepped, and the sustained rate is one item per cycle as long as
// the result side takes items. A result left waiting holds the input register
// and drops s_tready until the result side takes it. Commands (tap reset, IR
// shift, DR shift, run-idle wait) load the sequence while idle and are flagged
// as rejected otherwise; each tick item is one TCK period and its result
// carries the TMS and TDI levels for it.
module jtag_tap_shift_sequencer_core #(
	parameter int MAX_SHIFT_BITS   = 32,
	parameter int RESET_TMS_CLOCKS = 8,
	parameter int WAIT_COUNT_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bit_count[5:0], shift_value[37:6], wait_ticks[61:38], tdo_level[62], zero[63]
	input  logic [63:0] s_tdata,
	// func[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tms_level[0], tdi_level[1], tck_pulse[2], busy_res[3], done_res[4],
	// captured[36:5], rejected[37], zero[39:38]
	output logic [39:0] m_tdata
);

	localparam int CNT_W       = $clog2(MAX_SHIFT_BITS + 1);
	localparam int WAIT_USED_W = (WAIT_COUNT_BITS < jtss_pkg::WAIT_W) ? WAIT_COUNT_BITS
		: jtss_pkg::WAIT_W;
	localparam int RST_W       = $clog2(RESET_TMS_CLOCKS + 1);
	localparam int TICK_W      = (WAIT_USED_W > RST_W) ? WAIT_USED_W : RST_W;

	jtss_pkg::item_t   item_s1;
	logic              valid_s1;
	jtss_pkg::result_t res_q;
	logic              out_valid_q;
	logic              advance;

	jtss_pkg::phase_t          phase_q,       phase_nx;
	jtss_pkg::func_t           cmd_q,         cmd_nx;
	logic [CNT_W-1:0]          bits_left_q,   bits_left_nx;
	logic [CNT_W-1:0]          shift_total_q, shift_total_nx;
	logic [MAX_SHIFT_BITS-1:0] shift_reg_q,   shift_reg_nx;
	logic [TICK_W-1:0]         ticks_left_q,  ticks_left_nx;
	logic                      tdi_hold_q,    tdi_hold_nx;
	jtss_pkg::result_t         res_nx;

	// step the held item when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func        <= s_tuser;
			item_s1.bit_count   <= s_tdata[5:0];
			item_s1.shift_value <= s_tdata[37:6];
			item_s1.wait_ticks  <= s_tdata[61:38];
			item_s1.tdo_level   <= s_tdata[62];
		end
	end

	jtss_step #(
		.MAX_SHIFT_BITS   (MAX_SHIFT_BITS),
		.RESET_TMS_CLOCKS (RESET_TMS_CLOCKS),
		.CNT_W            (CNT_W),
		.TICK_W           (TICK_W),
		.WAIT_USED_W      (WAIT_USED_W)
	) u_step (
		.item           (item_s1),
		.phase          (phase_q),
		.cmd            (cmd_q),
		.bits_left      (bits_left_q),
		.shift_total    (shift_total_q),
		.shift_reg      (shift_reg_q),
		.ticks_left     (ticks_left_q),
		.tdi_hold       (tdi_hold_q),
		.phase_nx       (phase_nx),
		.cmd_nx         (cmd_nx),
		.bits_left_nx   (bits_left_nx),
		.shift_total_nx (shift_total_nx),
		.shift_reg_nx   (shift_reg_nx),
		.ticks_left_nx  (ticks_left_nx),
		.tdi_hold_nx    (tdi_hold_nx),
		.res            (res_nx)
	);

	// sequencer state, committed once per stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= jtss_pkg::PH_IDLE;
			cmd_q         <= jtss_pkg::FUNC_TICK;
			bits_left_q   <= '0;
			shift_total_q <= '0;
			shift_reg_q   <= '0;
			ticks_left_q  <= '0;
			tdi_hold_q    <= 1'b1;
		end else if (advance) begin
			phase_q       <= phase_nx;
			cmd_q         <= cmd_nx;
			bits_left_q   <= bits_left_nx;
			shift_total_q <= shift_total_nx;
			shift_reg_q   <= shift_reg_nx;
			ticks_left_q  <= ticks_left_nx;
			tdi_hold_q    <= tdi_hold_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.rejected, res_q.captured, res_q.done_res,
		res_q.busy_res, res_q.tck_pulse, res_q.tdi_level, res_q.tms_level};

	// a rejected command never clocks the TAP
	a_reject_no_tck: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37] |-> !m_tdata[2] && m_tdata[3])
		else $error("rejected item issued a TCK pulse");

	// completion only on a clocked tick, and it leaves the sequencer idle
	a_done_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[2] && !m_tdata[3])
		else $error("done without TCK or while still busy");

	// captured data only on a finishing result
	a_capture_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[36:5] != 32'd0) |-> m_tdata[4])
		else $error("captured data outside a finished shift");

	// the shift phase never runs with no bits left
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == jtss_pkg::PH_SHIFT |-> bits_left_q != '0)
		else $error("shift phase with empty bit count");

	// a stepped item always produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("stepped item produced no result");

endmodule

### sim/jtag_tap_shift_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JTAG TAP shift sequencer core testbench
// Drives command and tick items into the sequencer, predicts each result from
// a local copy of the TAP walk, shift register and counters, and compares every
// result field by field under random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module jtag_tap_shift_sequencer_core_tb;

	localparam int TAP_RESET_CLOCKS = 8;
	localparam int SHIFT_MAX        = 32;
	localparam int SETTLE_CYCLES    = 12;

	// command codes with no meaning of their own; the block takes them as ticks
	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int mismatches    = 0;

	// predicted sequencer state
	jtss_pkg::phase_t seq_ph;
	logic [2:0]       run_cmd;
	int unsigned      bits_rem;
	int unsigned      shift_len;
	int unsigned      ticks_rem;
	logic [31:0]      shift_q;
	logic             tdi_q;

	jtss_pkg::result_t tap_results_q[$];

	jtag_tap_shift_sequencer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] low_bits(input int unsigned n);
		return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
	endfunction

	// advance the local TAP state by one item and return the result it gives
	function automatic jtss_pkg::result_t predict_tap_step(input jtss_pkg::item_t it);
		jtss_pkg::result_t r;
		int unsigned       n;
		r = '0;
		r.tdi_level = tdi_q;
		if (it.func >= jtss_pkg::FUNC_RESET && it.func <= jtss_pkg::FUNC_WAIT) begin
			r.busy_res = 1'b1;
			if (seq_ph != jtss_pkg::PH_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				run_cmd = it.func;
				case (it.func)
					jtss_pkg::FUNC_RESET: begin
						ticks_rem = TAP_RESET_CLOCKS;
						seq_ph = jtss_pkg::PH_RESET;
					end
					jtss_pkg::FUNC_WAIT: begin
						ticks_rem = (it.wait_ticks == '0) ? 32'd1 : 32'(it.wait_ticks);
						seq_ph = jtss_pkg::PH_WAIT;
					end
					default: begin
						n = 32'(it.bit_count);
						if (n == 0)
							n = 1;
						if (n > SHIFT_MAX)
							n = SHIFT_MAX;
						shift_len = n;
						bits_rem = n;
						shift_q = it.shift_value & low_bits(n);
						seq_ph = jtss_pkg::PH_SEL_DR;
					end
				endcase
			end
		end else if (seq_ph != jtss_pkg::PH_IDLE) begin
			r.tck_pulse = 1'b1;
			case (seq_ph)
				jtss_pkg::PH_RESET, jtss_pkg::PH_WAIT: begin
					r.tms_level = (seq_ph == jtss_pkg::PH_RESET);
					ticks_rem--;
					if (ticks_rem == 0) begin
						seq_ph = jtss_pkg::PH_IDLE;
						r.done_res = 1'b1;
					end
				end
				jtss_pkg::PH_SEL_DR: begin
					r.tms_level = 1'b1;
					seq_ph = (run_cmd == jtss_pkg::FUNC_IR) ? jtss_pkg::PH_SEL_IR
						: jtss_pkg::PH_TO_CAPTURE;
				end
				jtss_pkg::PH_SEL_IR: begin
					r.tms_level = 1'b1;
					seq_ph = jtss_pkg::PH_TO_CAPTURE;
				end
				jtss_pkg::PH_TO_CAPTURE: begin
					seq_ph = jtss_pkg::PH_TO_SHIFT;
				end
				jtss_pkg::PH_TO_SHIFT: begin
					seq_ph = jtss_pkg::PH_SHIFT;
				end
				jtss_pkg::PH_SHIFT: begin
					// send the low bit, take TDO in at the top of the count
					r.tdi_level = shift_q[0];
					tdi_q = shift_q[0];
					r.tms_level = (bits_rem <= 1);
					shift_q = (shift_q >> 1) | ({31'b0, it.tdo_level} << (shift_len - 1));
					if (bits_rem > 0)
						bits_rem--;
					if (bits_rem == 0)
						seq_ph = jtss_pkg::PH_UPDATE;
				end
				jtss_pkg::PH_UPDATE: begin
					r.tms_level = 1'b1;
					seq_ph = jtss_pkg::PH_RTI;
				end
				default: begin
					seq_ph = jtss_pkg::PH_IDLE;
					r.done_res = 1'b1;
					r.captured = shift_q & low_bits(shift_len);
				end
			endcase
			r.busy_res = (seq_ph != jtss_pkg::PH_IDLE);
		end
		return r;
	endfunction

	// offer one item, idling beforehand at the current rate, and log its result
	task automatic send_item(input jtss_pkg::item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= {1'b0, it.tdo_level, it.wait_ticks, it.shift_value, it.bit_count};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tap_results_q.push_back(predict_tap_step(it));
	endtask

	function automatic jtss_pkg::item_t random_item(input logic [2:0] fn);
		jtss_pkg::item_t it;
		it.func        = fn;
		it.bit_count   = 6'($urandom);
		it.shift_value = $urandom;
		it.wait_ticks  = 24'($urandom);
		it.tdo_level   = 1'($urandom);
		return it;
	endfunction

	task automatic send_tick(input logic [2:0] fn);
		send_item(random_item(fn));
	endtask

	task automatic send_command(input logic [2:0] fn, input logic [5:0] cnt,
			input logic [31:0] val, input logic [23:0] wt);
		jtss_pkg::item_t it;
		it = random_item(fn);
		it.bit_count   = cnt;
		it.shift_value = val;
		it.wait_ticks  = wt;
		send_item(it);
	endtask

	// clock the running sequence through to idle
	task automatic finish_sequence();
		while (seq_ph != jtss_pkg::PH_IDLE)
			send_tick(jtss_pkg::FUNC_TICK);
	endtask

	// hold the sender off until every logged result has come back
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tap_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		jtss_pkg::item_t it;
		src_idle_pct  = 14;
		sink_idle_pct = 54;
		// idle ticks with every field at either extreme: nothing moves
		it = '1;
		it.func = jtss_pkg::FUNC_TICK;
		send_item(it);
		it = '0;
		it.func = FUNC_SPARE_HI;
		send_item(it);
		// tap reset, with a run-idle wait turned away part way through
		send_command(jtss_pkg::FUNC_RESET, '0, '0, '0);
		send_tick(jtss_pkg::FUNC_TICK);
		send_command(jtss_pkg::FUNC_WAIT, '1, '1, '1);
		finish_sequence();
		// IR shift of zero bits runs as one bit
		send_command(jtss_pkg::FUNC_IR, 6'd0, 32'hFFFF_FFFF, '0);
		finish_sequence();
		// full width DR shift, with a spare code and a turned-away IR in flight
		send_command(jtss_pkg::FUNC_DR, 6'd32, 32'hA5C3_5A3C, '0);
		send_tick(jtss_pkg::FUNC_TICK);
		send_tick(FUNC_SPARE_LO);
		send_command(jtss_pkg::FUNC_IR, 6'd8, 32'h0000_00FF, '0);
		finish_sequence();
		// oversized count saturates, value bits above the count drop
		send_command(jtss_pkg::FUNC_DR, 6'd63, 32'hFFFF_FFFF, '0);
		finish_sequence();
		send_command(jtss_pkg::FUNC_IR, 6'd5, 32'hFFFF_FFFF, '0);
		finish_sequence();
		// a single zero bit leaves TDI held low on the idle tick after it
		send_command(jtss_pkg::FUNC_IR, 6'd1, 32'h0000_0000, '0);
		finish_sequence();
		send_tick(jtss_pkg::FUNC_TICK);
		// run-idle waits of zero and of a few ticks
		send_command(jtss_pkg::FUNC_WAIT, '0, '0, 24'd0);
		finish_sequence();
		send_command(jtss_pkg::FUNC_WAIT, '0, '0, 24'd3);
		finish_sequence();
		wait_results_drained();
	endtask

	// well-formed command sequences with random content, salted with noise
	task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
		jtss_pkg::item_t it;
		int              counted;
		int              pick;
		counted = 0;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		while (counted < n_items) begin
			it = random_item(jtss_pkg::FUNC_TICK);
			pick = int'($urandom_range(99));
			if (seq_ph == jtss_pkg::PH_IDLE) begin
				if (pick < 5) begin
					it.func = jtss_pkg::FUNC_TICK;
				end else if (pick < 8) begin
					it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
				end else begin
					case ($urandom_range(9))
						0, 1:    it.func = jtss_pkg::FUNC_RESET;
						2, 3, 4: it.func = jtss_pkg::FUNC_IR;
						5, 6, 7: it.func = jtss_pkg::FUNC_DR;
						default: it.func = jtss_pkg::FUNC_WAIT;
					endcase
					// keep most shifts and waits short
					case ($urandom_range(9))
						0:       it.bit_count = 6'd0;
						1:       it.bit_count = 6'($urandom_range(33, 63));
						2:       it.bit_count = 6'd32;
						default: it.bit_count = 6'($urandom_range(1, 16));
					endcase
					it.wait_ticks = ($urandom_range(9) == 0) ? 24'd0
						: 24'($urandom_range(1, 12));
					counted++;
				end
			end else begin
				if (pick < 10)
					it.func = 3'($urandom_range(jtss_pkg::FUNC_RESET, jtss_pkg::FUNC_WAIT));
				else if (pick < 15)
					it.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
				if (!(it.func >= jtss_pkg::FUNC_RESET && it.func <= jtss_pkg::FUNC_WAIT))
					counted++;
			end
			send_item(it);
			if ($urandom_range(99) == 0)
				wait_results_drained();
		end
		wait_results_drained();
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// compare each result with the oldest prediction, then pick the next stall
	always @(posedge clk) begin : check_results
		jtss_pkg::result_t want;
		jtss_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.tms_level = m_tdata[0];
			got.tdi_level = m_tdata[1];
			got.tck_pulse = m_tdata[2];
			got.busy_res  = m_tdata[3];
			got.done_res  = m_tdata[4];
			got.captured  = m_tdata[36:5];
			got.rejected  = m_tdata[37];
			if (tap_results_q.size() == 0) begin
				$error("result item with no prediction waiting: %h", m_tdata);
				mismatches++;
			end else begin
				want = tap_results_q.pop_front();
				compare_field("tms_level", 32'(want.tms_level), 32'(got.tms_level));
				compare_field("tdi_level", 32'(want.tdi_level), 32'(got.tdi_level));
				compare_field("tck_pulse", 32'(want.tck_pulse), 32'(got.tck_pulse));
				compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
				compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
				compare_field("captured", want.captured, got.captured);
				compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = jtss_pkg::FUNC_TICK;
		seq_ph    = jtss_pkg::PH_IDLE;
		run_cmd   = jtss_pkg::FUNC_TICK;
		bits_rem  = 0;
		shift_len = 0;
		ticks_rem = 0;
		shift_q   = '0;
		tdi_q     = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(150, 14, 54);
		test_random(150, 54, 14);
		test_random(150, 0, 0);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && tap_results_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
